### src/lcs_pkg.sv
// Shared definitions for the LCS length engine: request function codes and
// the width and ceiling of the reported length. No dependencies.
`default_nettype none

package lcs_pkg;

  localparam int FUNC_W = 2;
  localparam int LEN_W  = 7;

  localparam logic [FUNC_W-1:0] FUNC_FIRST   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SECOND  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // Largest length the result port can show; longer results saturate.
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

endpackage

`default_nettype wire

### src/lcs_mem.sv
// Simple dual-port memory, one write port and one registered read port.
// Used for both strings and for the table row. No dependencies.
`default_nettype none

module lcs_mem #(
  parameter int DW    = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/lcs_cell.sv
// Shared table-cell unit: symbol compare, diagonal increment and three-way
// maximum. Purely combinational; no dependencies.
`default_nettype none

module lcs_cell #(
  parameter int SW = 8,
  parameter int CW = 7
) (
  input  wire logic [SW-1:0] a,
  input  wire logic [SW-1:0] b,
  input  wire logic [CW-1:0] diag,
  input  wire logic [CW-1:0] left,
  input  wire logic [CW-1:0] up,
  output logic      [CW-1:0] value
);

  logic [CW-1:0] max_lu;
  logic [CW-1:0] max_all;

  always_comb begin
    max_lu  = (left > up) ? left : up;
    max_all = (max_lu > diag) ? max_lu : diag;
    if (a == b) begin
      value = CW'(diag + 1'b1);
    end else begin
      value = max_all;
    end
  end

endmodule

`default_nettype wire

### src/lcs_length_dp.sv
// Top level of the LCS length engine: request decode, table-walk sequencer
// and result register. Depends on lcs_pkg, lcs_mem and lcs_cell.
`default_nettype none

// This block computes the length of the longest common subsequence of two
// strings that are loaded one character per request. A request is taken
// when start is high and busy is low. Function FIRST or SECOND appends the
// symbol to that string without raising busy, so appends may follow each
// other every cycle; a string that already holds MAX_LEN characters drops
// the symbol and sets the overflow flag. Function COMPUTE walks the dynamic
// programming table row by row through one shared cell unit, keeping a
// single table row in memory. Each row first fetches its character of the
// first string; each cell then takes a registered read of the second
// string and the row, then the update and write back. done is registered
// from the update of the last cell and rises as busy falls. If either
// string is empty the result comes in the cycle after the request. done
// is high for exactly one cycle with lcs_length and overflow valid; the
// receiver cannot stall it, so capture the result on that cycle. The
// compute also empties both strings and clears the overflow flag. Unused
// function code 3 is accepted and does nothing.
module lcs_length_dp #(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [lcs_pkg::FUNC_W-1:0] func,
  input  wire logic [7:0]                 symbol,
  output logic                            done,
  output logic      [lcs_pkg::LEN_W-1:0]  lcs_length,
  output logic                            overflow
);

  import lcs_pkg::*;

  // Stored symbol width: the port carries eight bits at most.
  localparam int SW = (SYMBOL_BITS < 8) ? SYMBOL_BITS : 8;
  // Counts and table values run from 0 to MAX_LEN.
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_ROW     = 2'd1;
  localparam logic [1:0] ST_CELL_RD = 2'd2;
  localparam logic [1:0] ST_CELL_EX = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] first_count;
  logic [CW-1:0] second_count;
  logic          dropped_flag;
  logic [CW-1:0] i_cnt;
  logic [CW-1:0] j_cnt;
  logic [CW-1:0] diag;
  logic [CW-1:0] left;

  logic          accept;
  logic          first_full;
  logic          second_full;
  logic          either_empty;
  logic          last_col;
  logic          last_row;
  logic          emit;
  logic [LEN_W-1:0] emit_len;

  logic [SW-1:0] sym_masked;
  logic [SW-1:0] first_q;
  logic [SW-1:0] second_q;
  logic [CW-1:0] row_q;
  logic [CW-1:0] up;
  logic [CW-1:0] cell_value;
  logic [CW+LEN_W-1:0] value_ext;

  assign busy         = (state != ST_IDLE);
  assign accept       = start && !busy;
  assign sym_masked   = symbol[SW-1:0];
  assign first_full   = (first_count == CW'(MAX_LEN));
  assign second_full  = (second_count == CW'(MAX_LEN));
  assign either_empty = (first_count == '0) || (second_count == '0);
  assign last_col     = (CW'(j_cnt + 1'b1) == second_count);
  assign last_row     = (CW'(i_cnt + 1'b1) == first_count);

  // The first row has no row above it; its upper cells are zero. This
  // stands in for clearing the stored row before the walk.
  assign up = (i_cnt == '0) ? '0 : row_q;

  lcs_mem #(.DW(SW), .DEPTH(MAX_LEN), .AW(IW)) u_first_mem (
    .clk   (clk),
    .we    (accept && (func == FUNC_FIRST) && !first_full),
    .waddr (first_count[IW-1:0]),
    .wdata (sym_masked),
    .re    (state == ST_ROW),
    .raddr (i_cnt[IW-1:0]),
    .rdata (first_q)
  );

  lcs_mem #(.DW(SW), .DEPTH(MAX_LEN), .AW(IW)) u_second_mem (
    .clk   (clk),
    .we    (accept && (func == FUNC_SECOND) && !second_full),
    .waddr (second_count[IW-1:0]),
    .wdata (sym_masked),
    .re    (state == ST_CELL_RD),
    .raddr (j_cnt[IW-1:0]),
    .rdata (second_q)
  );

  lcs_mem #(.DW(CW), .DEPTH(MAX_LEN), .AW(IW)) u_row_mem (
    .clk   (clk),
    .we    (state == ST_CELL_EX),
    .waddr (j_cnt[IW-1:0]),
    .wdata (cell_value),
    .re    (state == ST_CELL_RD),
    .raddr (j_cnt[IW-1:0]),
    .rdata (row_q)
  );

  lcs_cell #(.SW(SW), .CW(CW)) u_cell (
    .a     (first_q),
    .b     (second_q),
    .diag  (diag),
    .left  (left),
    .up    (up),
    .value (cell_value)
  );

  // A result goes out either straight from an empty compute request or
  // after the last cell of the last row. Lengths beyond the port saturate.
  assign value_ext = {{LEN_W{1'b0}}, cell_value};

  always_comb begin
    emit     = 1'b0;
    emit_len = '0;
    if (state == ST_IDLE) begin
      emit = accept && (func == FUNC_COMPUTE) && either_empty;
    end else if (state == ST_CELL_EX) begin
      emit = last_col && last_row;
      if (value_ext > {{CW{1'b0}}, LEN_SAT}) begin
        emit_len = LEN_SAT;
      end else begin
        emit_len = value_ext[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      first_count  <= '0;
      second_count <= '0;
      dropped_flag <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= emit;
      if (emit) begin
        first_count  <= '0;
        second_count <= '0;
        dropped_flag <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (func)
              FUNC_FIRST: begin
                if (first_full) begin
                  dropped_flag <= 1'b1;
                end else begin
                  first_count <= CW'(first_count + 1'b1);
                end
              end
              FUNC_SECOND: begin
                if (second_full) begin
                  dropped_flag <= 1'b1;
                end else begin
                  second_count <= CW'(second_count + 1'b1);
                end
              end
              FUNC_COMPUTE: begin
                if (!either_empty) begin
                  state <= ST_ROW;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_ROW: begin
          state <= ST_CELL_RD;
        end
        ST_CELL_RD: begin
          state <= ST_CELL_EX;
        end
        ST_CELL_EX: begin
          if (!last_col) begin
            state <= ST_CELL_RD;
          end else if (!last_row) begin
            state <= ST_ROW;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Walk indices and the running diagonal and left values.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        i_cnt <= '0;
      end
      ST_ROW: begin
        j_cnt <= '0;
        diag  <= '0;
        left  <= '0;
      end
      ST_CELL_EX: begin
        diag <= up;
        left <= cell_value;
        if (!last_col) begin
          j_cnt <= CW'(j_cnt + 1'b1);
        end else begin
          i_cnt <= CW'(i_cnt + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      lcs_length <= emit_len;
      overflow   <= dropped_flag;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the walk is still running");

  a_done_cleared: assert property (@(posedge clk) disable iff (rst)
    done |-> (first_count == '0) && (second_count == '0) && !dropped_flag)
    else $error("strings or overflow flag not cleared with the result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (first_count <= CW'(MAX_LEN)) && (second_count <= CW'(MAX_LEN)))
    else $error("string count beyond capacity");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CELL_EX) |-> (j_cnt < second_count) && (i_cnt < first_count))
    else $error("table walk index outside the loaded strings");

  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_COMPUTE) && !either_empty) |=> busy && !done)
    else $error("compute request on loaded strings did not start the walk");
`endif

endmodule

`default_nettype wire

### tb/sv/lcs_monitor.sv
// Result monitor for the LCS length engine: follows accepted requests, predicts
// each compute result and compares it with the strobed output. Needs lcs_pkg.
`timescale 1ns / 100ps

module lcs_monitor #(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [lcs_pkg::FUNC_W-1:0] func,
  input  logic [7:0]                 symbol,
  input  logic                       done,
  input  logic [lcs_pkg::LEN_W-1:0]  lcs_length,
  input  logic                       overflow,
  output int                         outstanding,
  output int                         mismatches,
  output int                         results_seen
);

  import lcs_pkg::*;

  localparam logic [7:0] SYM_MASK = 8'((1 << SYMBOL_BITS) - 1);

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ovf;
  } lcs_result_t;

  // Mirror of the block's string stores and counters.
  logic [7:0]  str_a [MAX_LEN];
  logic [7:0]  str_b [MAX_LEN];
  int unsigned len_a;
  int unsigned len_b;
  logic        dropped;

  lcs_result_t pending_lcs_q [$];
  lcs_result_t want;
  int          mismatch_count;
  int          checked_count;

  // Single-row walk of the LCS table over the loaded strings.
  function automatic logic [LEN_W-1:0] lcs_of_loaded();
    int row [MAX_LEN];
    int diag;
    int left_v;
    int up;
    int v;
    int best;
    if (len_a == 0 || len_b == 0) return '0;
    for (int j = 0; j < len_b; j++) row[j] = 0;
    for (int i = 0; i < len_a; i++) begin
      diag   = 0;
      left_v = 0;
      for (int j = 0; j < len_b; j++) begin
        up = row[j];
        if (str_a[i] == str_b[j]) begin
          v = diag + 1;
        end else begin
          v = (left_v > up) ? left_v : up;
          v = (v > diag) ? v : diag;
        end
        diag   = up;
        row[j] = v;
        left_v = v;
      end
    end
    best = row[len_b - 1];
    if (best > int'(LEN_SAT)) best = int'(LEN_SAT);
    return best[LEN_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t ns] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  initial begin
    mismatch_count = 0;
    checked_count  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      len_a   = 0;
      len_b   = 0;
      dropped = 1'b0;
      pending_lcs_q.delete();
    end else begin
      // The result strobe is handled before a request taken at the same edge.
      if (done === 1'b1) begin
        if (pending_lcs_q.size() == 0) begin
          report_mismatch($sformatf("result with no compute waiting (length %0d, overflow %0b)",
                                    lcs_length, overflow));
        end else begin
          want = pending_lcs_q.pop_front();
          if (lcs_length !== want.len)
            report_mismatch($sformatf("lcs_length %0d, expected %0d", lcs_length, want.len));
          if (overflow !== want.ovf)
            report_mismatch($sformatf("overflow %0b, expected %0b", overflow, want.ovf));
          checked_count++;
        end
      end
      if (start && !busy) begin
        case (func)
          FUNC_FIRST: begin
            if (len_a < MAX_LEN) begin
              str_a[len_a] = symbol & SYM_MASK;
              len_a++;
            end else begin
              dropped = 1'b1;
            end
          end
          FUNC_SECOND: begin
            if (len_b < MAX_LEN) begin
              str_b[len_b] = symbol & SYM_MASK;
              len_b++;
            end else begin
              dropped = 1'b1;
            end
          end
          FUNC_COMPUTE: begin
            want.len = lcs_of_loaded();
            want.ovf = dropped;
            pending_lcs_q.push_back(want);
            len_a   = 0;
            len_b   = 0;
            dropped = 1'b0;
          end
          default: ;
        endcase
      end
    end
    outstanding  <= pending_lcs_q.size();
    mismatches   <= mismatch_count;
    results_seen <= checked_count;
  end

endmodule

### tb/sv/tb.sv
// Top of the LCS length engine testbench: clock, reset, request stimulus and
// verdict. Instantiates lcs_length_dp and lcs_monitor; needs lcs_pkg.
`timescale 1ns / 100ps

module tb;

  import lcs_pkg::*;

  localparam int MAX_LEN      = 64;
  localparam int SYMBOL_BITS  = 8;
  localparam int RANDOM_ITEMS = 950;
  // Far beyond the slowest correct run of this stimulus, which takes under 0.8 ms.
  localparam longint LIMIT_NS = 64'd12_000_000;

  // The package names no code for the unused selector value.
  localparam logic [FUNC_W-1:0] FUNC_NOOP = 2'd3;

  // Every input of the block has a known value from time zero.
  logic              clk    = 1'b0;
  logic              rst    = 1'b1;
  logic              start  = 1'b0;
  logic [FUNC_W-1:0] func   = '0;
  logic [7:0]        symbol = '0;
  logic              busy;
  logic              done;
  logic [LEN_W-1:0]  lcs_length;
  logic              overflow;

  int outstanding;
  int mismatches;
  int results_seen;

  // Stimulus bookkeeping for the summary, and the burst flag that suppresses idle gaps.
  int  requests_sent = 0;
  int  computes_sent = 0;
  int  long_loads    = 0;
  bit  burst_mode    = 1'b0;

  always #2 clk = ~clk;

  lcs_length_dp #(
    .MAX_LEN    (MAX_LEN),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .symbol    (symbol),
    .done      (done),
    .lcs_length(lcs_length),
    .overflow  (overflow)
  );

  // The monitor sees the same pins as the block and does all the checking.
  lcs_monitor #(
    .MAX_LEN    (MAX_LEN),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .symbol      (symbol),
    .done        (done),
    .lcs_length  (lcs_length),
    .overflow    (overflow),
    .outstanding (outstanding),
    .mismatches  (mismatches),
    .results_seen(results_seen)
  );

  // Idle gap between requests: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // String length for one load: mostly short so the table walk stays cheap,
  // a few around capacity so that full strings and dropped symbols occur.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 1);
    if (r < 86) return $urandom_range(2, 12);
    if (r < 94) return $urandom_range(13, 40);
    return $urandom_range(MAX_LEN - 4, MAX_LEN + 8);
  endfunction

  // Presents one request and holds it until the block takes it. The edge at
  // which start is high and busy is low is the edge of acceptance; busy is
  // read as it stood before that edge. start stays high when no gap follows,
  // so it is never lowered and raised in the same time step.
  task automatic issue_request(input logic [FUNC_W-1:0] f, input logic [7:0] s);
    int gap;
    start  <= 1'b1;
    func   <= f;
    symbol <= s;
    do @(posedge clk); while (busy);
    if (f != FUNC_NOOP) requests_sent++;
    if (f == FUNC_COMPUTE) computes_sent++;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      // While idle, the data pins carry junk that the block must ignore.
      start  <= 1'b0;
      func   <= FUNC_W'($urandom);
      symbol <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every predicted result has been strobed.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One well-formed request sequence: two strings loaded in random
  // interleaving, an occasional unused selector mixed in, then a compute.
  // Symbols come from a small alphabet around a random base most of the
  // time so that matches are frequent, and every bit still toggles.
  task automatic load_and_compute();
    int         len_a;
    int         len_b;
    int         na;
    int         nb;
    int         alpha_hi;
    int         r;
    logic [7:0] base;
    len_a = pick_len();
    len_b = pick_len();
    if (len_a > MAX_LEN || len_b > MAX_LEN) long_loads++;
    r = $urandom_range(0, 3);
    alpha_hi = (r == 0) ? 1 : (r == 1) ? 3 : (r == 2) ? 15 : 255;
    base = 8'($urandom);
    burst_mode = ($urandom_range(0, 3) == 0);
    na = 0;
    nb = 0;
    while (na < len_a || nb < len_b) begin
      if ($urandom_range(0, 19) == 0) begin
        issue_request(FUNC_NOOP, 8'($urandom));
      end else if (nb >= len_b || (na < len_a && $urandom_range(0, 1) == 1)) begin
        issue_request(FUNC_FIRST, base ^ 8'($urandom_range(0, alpha_hi)));
        na++;
      end else begin
        issue_request(FUNC_SECOND, base ^ 8'($urandom_range(0, alpha_hi)));
        nb++;
      end
    end
    issue_request(FUNC_COMPUTE, 8'($urandom));
    burst_mode = 1'b0;
  endtask

  initial begin : stimulus
    int goal;
    int r;
    int n;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests. Both strings empty gives zero.
    issue_request(FUNC_COMPUTE, 8'h00);
    // The unused selector changes nothing, even with all symbol bits set.
    issue_request(FUNC_NOOP, 8'hFF);
    issue_request(FUNC_COMPUTE, 8'hFF);
    // Only one string loaded: still zero, for either side.
    issue_request(FUNC_FIRST, 8'h00);
    issue_request(FUNC_COMPUTE, 8'h00);
    issue_request(FUNC_SECOND, 8'hFF);
    issue_request(FUNC_COMPUTE, 8'h00);
    // Single matching symbols at the top of the range.
    issue_request(FUNC_FIRST, 8'hFF);
    issue_request(FUNC_SECOND, 8'hFF);
    issue_request(FUNC_COMPUTE, 8'h00);
    // Crossed order of the two extremes, with an unused selector between.
    issue_request(FUNC_FIRST, 8'h00);
    issue_request(FUNC_FIRST, 8'hFF);
    issue_request(FUNC_NOOP, 8'h55);
    issue_request(FUNC_SECOND, 8'hFF);
    issue_request(FUNC_SECOND, 8'h00);
    issue_request(FUNC_COMPUTE, 8'hAA);
    // Identical strings back to back without idling.
    burst_mode = 1'b1;
    for (int k = 1; k <= 3; k++) issue_request(FUNC_FIRST, 8'(k));
    for (int k = 1; k <= 3; k++) issue_request(FUNC_SECOND, 8'(k));
    issue_request(FUNC_COMPUTE, 8'h00);
    burst_mode = 1'b0;

    // Let everything so far come out before random traffic starts.
    drain_results();

    // Random part: mostly well-formed sequences, some noise of random
    // selectors (which also makes broken sequences), and occasional pauses
    // until the block has delivered every pending result.
    goal = requests_sent + RANDOM_ITEMS;
    while (requests_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        load_and_compute();
      end else if (r < 96) begin
        n = $urandom_range(1, 4);
        repeat (n) issue_request(FUNC_W'($urandom), 8'($urandom));
      end else begin
        drain_results();
      end
    end

    // Wait out every pending result, then keep watching for any strobe that
    // should not come.
    drain_results();
    repeat (20) @(posedge clk);

    $display("Run covered %0d requests, %0d computes (%0d sequences past capacity).",
             requests_sent, computes_sent, long_loads);
    $display("Checked %0d results with %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("Timed out with %0d results still pending.", outstanding);
    $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
src/lcs_pkg.sv
src/lcs_mem.sv
src/lcs_cell.sv
src/lcs_length_dp.sv
tb/sv/lcs_monitor.sv
tb/sv/tb.sv
